// ===== rtl/fuel_level_estimator_top_defines.svh =====
// Assertion helpers for the fuel level estimator.
`ifndef FUEL_LEVEL_ESTIMATOR_TOP_DEFINES_SVH
`define FUEL_LEVEL_ESTIMATOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define FLE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define FLE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fle_pkg;

  localparam int unsigned AverageWindow = 64;

  localparam int unsigned AdcW   = 10;
  localparam int unsigned VolW   = 16;
  localparam int unsigned CntW   = 7;
  localparam int unsigned SumW   = 16;
  localparam int unsigned ProdW  = AdcW + VolW;
  localparam int unsigned StepW  = 5;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned IdxW   = 2;

  localparam logic [AdcW-1:0] EmptyAdcRst  = 10'd122;
  localparam logic [AdcW-1:0] FullAdcRst   = 10'd410;
  localparam logic [VolW-1:0] FullVolRst   = 16'd63000;
  localparam logic [CntW-1:0] WarmupRst    = 7'd60;
  localparam logic [CntW-1:0] WindowLimit  = CntW'(AverageWindow);

  // Iterations of the bit-serial units
  localparam logic [StepW-1:0] Div1Steps = StepW'(SumW);
  localparam logic [StepW-1:0] MulSteps  = StepW'(AdcW);
  localparam logic [StepW-1:0] Div2Steps = StepW'(ProdW);

  localparam logic [IdxW-1:0] RegEmptyAdc = 2'd0;
  localparam logic [IdxW-1:0] RegFullAdc  = 2'd1;
  localparam logic [IdxW-1:0] RegFullVol  = 2'd2;
  localparam logic [IdxW-1:0] RegWarmup   = 2'd3;

  localparam logic OpSample  = 1'b0;
  localparam logic OpRestart = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV1 = 6'b000010,
    ST_MAP  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_DIV2 = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/fuel_level_estimator_top.sv =====
// Channel   Signals                                           Direction
// config    cfg_we_i, cfg_idx_i, cfg_data_i                   in, write only
// request   in_valid_i/in_ready_o: operation, sensor_adc, used_ml   in
// result    out_valid_o/out_ready_i: level_ml                 out
//
// One request at a time. A restart request gives no result and leaves the block ready.
// A tracking request goes straight to the output state, which registers its result.
// A warm-up request runs a 16-step bit-serial divide for the mean, a map step,
// a 10-step shift-add multiply and a 26-step divide.
// Reset clears state and loads the default register values at once.
// A full result register stalls the block in its output state until taken.
`timescale 1ns / 1ps
`default_nettype none
`include "fuel_level_estimator_top_defines.svh"

module fuel_level_estimator_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [fle_pkg::IdxW-1:0]  cfg_idx_i,
  input  wire logic [fle_pkg::CfgW-1:0]  cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      operation_i,
  input  wire logic [fle_pkg::AdcW-1:0]  sensor_adc_i,
  input  wire logic [fle_pkg::VolW-1:0]  used_ml_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [fle_pkg::VolW-1:0]       level_ml_o
);

  fle_pkg::state_e state_q, state_d;

  logic [fle_pkg::AdcW-1:0]  empty_q, full_q;
  logic [fle_pkg::VolW-1:0]  vol_q;
  logic [fle_pkg::CntW-1:0]  warm_q;

  logic [fle_pkg::SumW-1:0]  sum_q, sum_d;
  logic [fle_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [fle_pkg::VolW-1:0]  level_q, level_d;

  logic [fle_pkg::ProdW-1:0] quo_q, quo_d;
  logic [fle_pkg::AdcW-1:0]  rem_q, rem_d;
  logic [fle_pkg::AdcW-1:0]  div_q, div_d;
  logic [fle_pkg::AdcW-1:0]  mul_q, mul_d;
  logic [fle_pkg::StepW-1:0] steps_q, steps_d;

  logic                      out_valid_q, out_valid_d;
  logic [fle_pkg::VolW-1:0]  out_level_q, out_level_d;

  logic                      accept;
  logic [fle_pkg::CntW-1:0]  limit;
  logic                      warming;
  logic [fle_pkg::SumW-1:0]  sum_next;
  logic [fle_pkg::CntW-1:0]  cnt_next;

  logic [fle_pkg::AdcW:0]    trial;
  logic [fle_pkg::AdcW:0]    trial_diff;
  logic                      qbit;
  logic [fle_pkg::ProdW-1:0] quo_step;
  logic [fle_pkg::AdcW-1:0]  rem_step;

  logic [fle_pkg::AdcW-1:0]  mean;
  logic [fle_pkg::AdcW-1:0]  offset;
  logic [fle_pkg::ProdW-1:0] addend;
  logic                      out_free;

  assign in_ready_o  = (state_q == fle_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign level_ml_o  = out_level_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign limit    = (warm_q > fle_pkg::WindowLimit) ? fle_pkg::WindowLimit : warm_q;
  assign warming  = (cnt_q < limit);
  assign sum_next = sum_q + fle_pkg::SumW'(sensor_adc_i);
  assign cnt_next = cnt_q + fle_pkg::CntW'(1);

  // Restoring divide step, shared by both divisions
  assign trial      = {rem_q, quo_q[fle_pkg::ProdW-1]};
  assign trial_diff = trial - {1'b0, div_q};
  assign qbit       = (trial >= {1'b0, div_q});
  assign rem_step   = qbit ? trial_diff[fle_pkg::AdcW-1:0] : trial[fle_pkg::AdcW-1:0];
  assign quo_step   = {quo_q[fle_pkg::ProdW-2:0], qbit};

  // Clamp the mean into the span
  assign mean = quo_q[fle_pkg::AdcW-1:0];
  always_comb begin
    if (mean < empty_q) begin
      offset = '0;
    end else if (mean > full_q) begin
      offset = full_q - empty_q;
    end else begin
      offset = mean - empty_q;
    end
  end

  assign addend = mul_q[fle_pkg::AdcW-1] ? fle_pkg::ProdW'(vol_q) : '0;

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    level_d     = level_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    div_d       = div_q;
    mul_d       = mul_q;
    steps_d     = steps_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_level_d = out_level_q;

    case (state_q)
      fle_pkg::ST_IDLE: begin
        if (accept) begin
          if (operation_i == fle_pkg::OpRestart) begin
            sum_d = '0;
            cnt_d = '0;
          end else if (warming) begin
            sum_d   = sum_next;
            cnt_d   = cnt_next;
            quo_d   = {sum_next, fle_pkg::AdcW'(0)};
            rem_d   = '0;
            div_d   = fle_pkg::AdcW'(cnt_next);
            steps_d = fle_pkg::Div1Steps - fle_pkg::StepW'(1);
            state_d = fle_pkg::ST_DIV1;
          end else begin
            level_d = (level_q > used_ml_i) ? level_q - used_ml_i : '0;
            state_d = fle_pkg::ST_OUT;
          end
        end
      end
      fle_pkg::ST_DIV1: begin
        quo_d   = quo_step;
        rem_d   = rem_step;
        steps_d = steps_q - fle_pkg::StepW'(1);
        if (steps_q == '0) begin
          state_d = fle_pkg::ST_MAP;
        end
      end
      fle_pkg::ST_MAP: begin
        if (full_q <= empty_q) begin
          level_d = '0;
          state_d = fle_pkg::ST_OUT;
        end else begin
          mul_d   = offset;
          quo_d   = '0;
          div_d   = full_q - empty_q;
          steps_d = fle_pkg::MulSteps - fle_pkg::StepW'(1);
          state_d = fle_pkg::ST_MUL;
        end
      end
      fle_pkg::ST_MUL: begin
        // Shift-add, multiplier MSB first
        quo_d   = {quo_q[fle_pkg::ProdW-2:0], 1'b0} + addend;
        mul_d   = {mul_q[fle_pkg::AdcW-2:0], 1'b0};
        steps_d = steps_q - fle_pkg::StepW'(1);
        if (steps_q == '0) begin
          rem_d   = '0;
          steps_d = fle_pkg::Div2Steps - fle_pkg::StepW'(1);
          state_d = fle_pkg::ST_DIV2;
        end
      end
      fle_pkg::ST_DIV2: begin
        quo_d   = quo_step;
        rem_d   = rem_step;
        steps_d = steps_q - fle_pkg::StepW'(1);
        if (steps_q == '0) begin
          level_d = quo_step[fle_pkg::VolW-1:0];
          state_d = fle_pkg::ST_OUT;
        end
      end
      fle_pkg::ST_OUT: begin
        // Hold until the result register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_level_d = level_q;
          state_d     = fle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fle_pkg::ST_IDLE;
      empty_q     <= fle_pkg::EmptyAdcRst;
      full_q      <= fle_pkg::FullAdcRst;
      vol_q       <= fle_pkg::FullVolRst;
      warm_q      <= fle_pkg::WarmupRst;
      sum_q       <= '0;
      cnt_q       <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fle_pkg::RegEmptyAdc: empty_q <= cfg_data_i[fle_pkg::AdcW-1:0];
          fle_pkg::RegFullAdc:  full_q  <= cfg_data_i[fle_pkg::AdcW-1:0];
          fle_pkg::RegFullVol:  vol_q   <= cfg_data_i[fle_pkg::VolW-1:0];
          fle_pkg::RegWarmup:   warm_q  <= cfg_data_i[fle_pkg::CntW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    div_q       <= div_d;
    mul_q       <= mul_d;
    steps_q     <= steps_d;
    out_level_q <= out_level_d;
  end

  `FLE_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_q), "state register not one-hot")
  `FLE_ASSERT_NOW(a_count_window, 1'b1, cnt_q <= fle_pkg::WindowLimit,
    "sample count beyond averaging window")
  `FLE_ASSERT_NOW(a_rem_below_div,
    (state_q == fle_pkg::ST_DIV1) || (state_q == fle_pkg::ST_DIV2), rem_q < div_q,
    "divider remainder not below divisor")
  `FLE_ASSERT_NEXT(a_track_to_out,
    accept && (operation_i == fle_pkg::OpSample) && !warming, state_q == fle_pkg::ST_OUT,
    "tracking request did not go straight to output")

endmodule

`default_nettype wire
